### src/rmma_pkg.sv
// Shared types and constants for the region-mapped memory access block.
// Holds the controller states, the command and status words between the
// controller and the datapath, and the register and status codes.
package rmma_pkg;

   // Fixed field widths of the bus word and the register port.
   localparam int ADDR_W     = 32;
   localparam int DATA_W     = 32;
   localparam int ATTR_W     = 8;
   localparam int WCODE_W    = 2;
   localparam int RBYTES_W   = 13;
   localparam int PERM_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Number of region register slots in the register map.
   localparam int REGION_SLOTS = 3;
   localparam int HIT_IDX_W    = 2;

   // Byte lanes of the store.
   localparam int LANES   = 4;
   localparam int LANE_W  = 2;
   localparam int NBYTE_W = 3;

   // Reset value of the critical attribute mask.
   localparam logic [ATTR_W-1:0] CRITICAL_MASK_RESET = 8'hFF;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_REGION0_BASE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION1_BASE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION2_BASE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION0_BYTES  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION1_BYTES  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION2_BYTES  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PERMISSIONS    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_MASK  = 3'd7;

   // Access command and width codes.
   localparam logic CMD_WRITE = 1'b1;
   localparam logic [WCODE_W-1:0] WIDTH_BYTE = 2'd0;
   localparam logic [WCODE_W-1:0] WIDTH_HALF = 2'd1;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SECTION = 2'd1,
      STATUS_ATTR    = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_ACCESS,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;
      logic req_load;
      logic decode_load;
      logic check_load;
      logic mem_en;
      logic rsp_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic rsp_free;
   } dp_status_type;

endpackage

### src/rmma_bank.sv
// One byte lane of the region store: a single-port byte memory.
// Read data is registered; no dependencies.
module rmma_bank #(
   parameter int DEPTH  = 3072,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wdata,
   output logic [7:0]        rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   // Write or read one byte per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### src/rmma_ctrl.sv
// Controller of the region-mapped memory access block.
// Sequences clearing, decode, check, store access and response; uses rmma_pkg.
module rmma_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rmma_pkg::dp_status_type dp_status,
   output rmma_pkg::ctrl_cmd_type  cmd
);

   import rmma_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (dp_status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: state_in = ST_CHECK;
         ST_CHECK:  state_in = ST_ACCESS;
         ST_ACCESS: state_in = ST_FINISH;
         ST_FINISH: begin
            if (dp_status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_en = 1'b1;
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.req_load = req_valid;
         end
         ST_DECODE: cmd.decode_load = 1'b1;
         ST_CHECK:  cmd.check_load  = 1'b1;
         ST_ACCESS: cmd.mem_en      = 1'b1;
         ST_FINISH: cmd.rsp_load    = dp_status.rsp_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### src/rmma_datapath.sv
// Datapath of the region-mapped memory access block: registers, region
// decode, protection check, byte-banked store and response register.
// Uses rmma_pkg and rmma_bank.
module rmma_datapath #(
   parameter int NUM_REGIONS  = 3,
   parameter int REGION_BYTES = 4096,
   parameter int ATTR_BITS    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [rmma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rmma_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                              req_cmd,
   input  logic [rmma_pkg::ADDR_W-1:0]       req_address,
   input  logic [rmma_pkg::WCODE_W-1:0]      req_width_code,
   input  logic [rmma_pkg::DATA_W-1:0]       req_write_value,
   input  logic [rmma_pkg::ATTR_W-1:0]       req_access_attr,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rmma_pkg::DATA_W-1:0]       rsp_read_value,
   output logic [1:0]                        rsp_status,
   input  rmma_pkg::ctrl_cmd_type            cmd,
   output rmma_pkg::dp_status_type           dp_status
);

   import rmma_pkg::*;

   localparam int TOTAL_BYTES = NUM_REGIONS * REGION_BYTES;
   localparam int ROWS        = (TOTAL_BYTES + LANES - 1) / LANES;
   localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_W      = $clog2(TOTAL_BYTES);
   localparam int OFF_W       = $clog2(REGION_BYTES);
   localparam int SIZE_W      = $clog2(REGION_BYTES + 1);
   localparam int CMP_W       = (SIZE_W > RBYTES_W) ? SIZE_W : RBYTES_W;
   localparam logic [ATTR_W-1:0] ATTR_MASK = ATTR_W'((1 << ATTR_BITS) - 1);

   // Configuration registers.
   logic [ADDR_W-1:0]   base_ff [REGION_SLOTS];
   logic [RBYTES_W-1:0] rbytes_ff [REGION_SLOTS];
   logic [PERM_W-1:0]   perm_ff;
   logic [ATTR_W-1:0]   crit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < REGION_SLOTS; r++) begin
            base_ff[r]   <= '0;
            rbytes_ff[r] <= '0;
         end
         perm_ff <= '0;
         crit_ff <= CRITICAL_MASK_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REGION0_BASE:  base_ff[0]   <= csr_write_data;
            CSR_REGION1_BASE:  base_ff[1]   <= csr_write_data;
            CSR_REGION2_BASE:  base_ff[2]   <= csr_write_data;
            CSR_REGION0_BYTES: rbytes_ff[0] <= csr_write_data[RBYTES_W-1:0];
            CSR_REGION1_BYTES: rbytes_ff[1] <= csr_write_data[RBYTES_W-1:0];
            CSR_REGION2_BYTES: rbytes_ff[2] <= csr_write_data[RBYTES_W-1:0];
            CSR_PERMISSIONS:   perm_ff      <= csr_write_data[PERM_W-1:0];
            CSR_CRITICAL_MASK: crit_ff      <= csr_write_data[ATTR_W-1:0];
            default: ;
         endcase
      end
   end

   // Region sizes saturated to the store size of one region.
   logic [SIZE_W-1:0] size_sat [REGION_SLOTS];

   always_comb begin
      for (int r = 0; r < REGION_SLOTS; r++) begin
         if (CMP_W'(rbytes_ff[r]) > CMP_W'(REGION_BYTES)) begin
            size_sat[r] = SIZE_W'(REGION_BYTES);
         end else begin
            size_sat[r] = SIZE_W'(rbytes_ff[r]);
         end
      end
   end

   // Request word captured on accept.
   logic               wr_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [NBYTE_W-1:0] nbytes_ff;
   logic [DATA_W-1:0]  wdata_ff;
   logic [ATTR_W-1:0]  attr_ff;
   logic [NBYTE_W-1:0] nbytes_in;

   always_comb begin
      case (req_width_code)
         WIDTH_BYTE: nbytes_in = NBYTE_W'(1);
         WIDTH_HALF: nbytes_in = NBYTE_W'(2);
         default:    nbytes_in = NBYTE_W'(4);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         wr_ff     <= req_cmd;
         addr_ff   <= req_address;
         nbytes_ff <= nbytes_in;
         wdata_ff  <= req_write_value;
         attr_ff   <= req_access_attr;
      end
   end

   // Decode: the first enabled region whose range holds the address.
   logic [ADDR_W:0]      diff [REGION_SLOTS];
   logic                 hit_in;
   logic [HIT_IDX_W-1:0] idx_in;
   logic [OFF_W-1:0]     off_in;
   logic [SIZE_W-1:0]    dsize_in;
   logic                 hit_ff;
   logic [HIT_IDX_W-1:0] idx_ff;
   logic [OFF_W-1:0]     off_ff;
   logic [SIZE_W-1:0]    dsize_ff;

   always_comb begin
      hit_in   = 1'b0;
      idx_in   = '0;
      off_in   = '0;
      dsize_in = '0;
      for (int r = REGION_SLOTS - 1; r >= 0; r--) begin
         diff[r] = {1'b0, addr_ff} - {1'b0, base_ff[r]};
         if ((r < NUM_REGIONS) && (size_sat[r] != '0) && !diff[r][ADDR_W] &&
             (diff[r][ADDR_W-1:0] < ADDR_W'(size_sat[r]))) begin
            hit_in   = 1'b1;
            idx_in   = HIT_IDX_W'(r);
            off_in   = diff[r][OFF_W-1:0];
            dsize_in = size_sat[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode_load) begin
         hit_ff   <= hit_in;
         idx_ff   <= idx_in;
         off_ff   <= off_in;
         dsize_ff <= dsize_in;
      end
   end

   // Check: bound overrun, attributes, and the byte slot in the store.
   logic [ATTR_W-1:0] rattr;
   logic [SLOT_W-1:0] slot_base;
   logic [SIZE_W:0]   end_pos;
   status_type        status_in;
   status_type        status_ff;
   logic [SLOT_W-1:0] slot_ff;

   always_comb begin
      case (idx_ff)
         2'd0: begin
            rattr     = perm_ff[7:0];
            slot_base = '0;
         end
         2'd1: begin
            rattr     = perm_ff[15:8];
            slot_base = SLOT_W'(REGION_BYTES);
         end
         default: begin
            rattr     = perm_ff[23:16];
            slot_base = SLOT_W'(2 * REGION_BYTES);
         end
      endcase
      end_pos = (SIZE_W + 1)'(off_ff) + (SIZE_W + 1)'(nbytes_ff);
      if (!hit_ff || (end_pos > (SIZE_W + 1)'(dsize_ff))) begin
         status_in = STATUS_SECTION;
      end else if ((rattr & attr_ff & crit_ff & ATTR_MASK) == '0) begin
         status_in = STATUS_ATTR;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check_load) begin
         status_ff <= status_in;
         slot_ff   <= slot_base + SLOT_W'(off_ff);
      end
   end

   // Clearing pass over the store rows after reset.
   logic [ROW_W-1:0] clr_row_ff;
   logic             clear_last;

   assign clear_last = (clr_row_ff == ROW_W'(ROWS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
      end else if (cmd.clear_en && !clear_last) begin
         clr_row_ff <= clr_row_ff + ROW_W'(1);
      end
   end

   // Byte lane addressing: lane b holds byte (b - start lane) of the word.
   logic [LANE_W-1:0] lane0;
   logic [ROW_W-1:0]  row0;
   logic              bank_we    [LANES];
   logic [ROW_W-1:0]  bank_addr  [LANES];
   logic [7:0]        bank_wdata [LANES];
   logic [7:0]        bank_rdata [LANES];

   assign lane0 = slot_ff[LANE_W-1:0];
   assign row0  = ROW_W'(slot_ff >> LANE_W);

   always_comb begin
      logic [LANE_W-1:0] pos;
      for (int b = 0; b < LANES; b++) begin
         pos = LANE_W'(b) - lane0;
         if (cmd.clear_en) begin
            bank_we[b]    = 1'b1;
            bank_addr[b]  = clr_row_ff;
            bank_wdata[b] = '0;
         end else begin
            bank_we[b]    = cmd.mem_en && (status_ff == STATUS_OK) &&
                            (wr_ff == CMD_WRITE) && (NBYTE_W'(pos) < nbytes_ff);
            bank_addr[b]  = row0 + ROW_W'(LANE_W'(b) < lane0);
            bank_wdata[b] = wdata_ff[8*pos +: 8];
         end
      end
   end

   for (genvar b = 0; b < LANES; b++) begin : g_bank
      rmma_bank #(
         .DEPTH  (ROWS),
         .ADDR_W (ROW_W)
      ) u_bank (
         .clock (clock),
         .we    (bank_we[b]),
         .addr  (bank_addr[b]),
         .wdata (bank_wdata[b]),
         .rdata (bank_rdata[b])
      );
   end

   // Assemble the read word little-endian, zero past the access width.
   logic [DATA_W-1:0] rdata_in;

   always_comb begin
      logic [LANE_W-1:0] src;
      rdata_in = '0;
      for (int i = 0; i < LANES; i++) begin
         src = lane0 + LANE_W'(i);
         if ((NBYTE_W'(i) < nbytes_ff) && (status_ff == STATUS_OK) &&
             (wr_ff != CMD_WRITE)) begin
            rdata_in[8*i +: 8] = bank_rdata[src];
         end
      end
   end

   // Response register: holds the word until it is taken.
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   status_type        rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff   <= rdata_in;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;

   assign dp_status.clear_last = clear_last;
   assign dp_status.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

### src/region_mapped_memory_access.sv
// Top level of the region-mapped memory access block.
// Joins the controller (rmma_ctrl) and the datapath (rmma_datapath); uses rmma_pkg.
//
//   Channel   Ports                Direction   Handshake
//   request   req_*                in          req_valid / req_ready
//   response  rsp_*                out         rsp_valid / rsp_ready
//   control   csr_*                in          csr_write_enable, no wait
//
// A word is accepted in the idle step and its response is registered after the steps
// of region decode, bound and attribute check, store access and response load;
// the block takes no new word until its response is loaded and it is back in idle.
// A stalled response holds the block in its response step with req_ready low.
// After reset the store is cleared one row of four bytes per cycle, over all
// ceil(NUM_REGIONS * REGION_BYTES / 4) rows (3072 at the defaults), with req_ready low.
module region_mapped_memory_access #(
   parameter int NUM_REGIONS  = 3,
   parameter int REGION_BYTES = 4096,
   parameter int ATTR_BITS    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [rmma_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rmma_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [rmma_pkg::ADDR_W-1:0]     req_address,
   input  logic [rmma_pkg::WCODE_W-1:0]    req_width_code,
   input  logic [rmma_pkg::DATA_W-1:0]     req_write_value,
   input  logic [rmma_pkg::ATTR_W-1:0]     req_access_attr,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rmma_pkg::DATA_W-1:0]     rsp_read_value,
   output logic [1:0]                      rsp_status
);

   import rmma_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // Sequencer.
   rmma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // Registers, decode, store and response word.
   rmma_datapath #(
      .NUM_REGIONS  (NUM_REGIONS),
      .REGION_BYTES (REGION_BYTES),
      .ATTR_BITS    (ATTR_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_cmd          (req_cmd),
      .req_address      (req_address),
      .req_width_code   (req_width_code),
      .req_write_value  (req_write_value),
      .req_access_attr  (req_access_attr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .dp_status        (dp_status)
   );

endmodule

### verif/region_mapped_memory_access_tb.sv
// Self-checking testbench for region_mapped_memory_access: a directed table, then random
// bus words in three idling phases, all scored against an in-bench region and byte-store
// predictor. Depends on rmma_pkg and the block's RTL only.
module region_mapped_memory_access_tb;
   import rmma_pkg::*;

   localparam int NUM_REGIONS  = 3;
   localparam int REGION_BYTES = 4096;
   localparam int STORE_BYTES  = NUM_REGIONS * REGION_BYTES;
   localparam int QUIET_LIMIT  = 20000;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_WORDS  = 200;
   localparam int PRINT_LIMIT  = 40;

   localparam logic CMD_READ = 1'b0;
   localparam logic [WCODE_W-1:0] WIDTH_WORD  = 2'd2;
   localparam logic [WCODE_W-1:0] WIDTH_SPARE = 2'd3;

   typedef struct packed {
      logic                cmd;
      logic [ADDR_W-1:0]   address;
      logic [WCODE_W-1:0]  width_code;
      logic [DATA_W-1:0]   write_value;
      logic [ATTR_W-1:0]   access_attr;
   } bus_access_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      status_type        status;
   } bus_reply_type;

   typedef enum logic {ROW_CSR, ROW_ACCESS} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_IDX_W-1:0]    index;
      logic [CSR_DATA_W-1:0]   value;
      bus_access_type          word;
      bit                      pinned;
      bus_reply_type           reply;
   } script_row_type;

   // Block ports; the inputs are driven to known values from time zero.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_cmd = 1'b0;
   logic [ADDR_W-1:0]     req_address = '0;
   logic [WCODE_W-1:0]    req_width_code = '0;
   logic [DATA_W-1:0]     req_write_value = '0;
   logic [ATTR_W-1:0]     req_access_attr = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DATA_W-1:0]     rsp_read_value;
   logic [1:0]            rsp_status;

   // Mirror of the register file and the byte store.
   logic [ADDR_W-1:0]   model_base  [NUM_REGIONS];
   logic [RBYTES_W-1:0] model_bytes [NUM_REGIONS];
   logic [PERM_W-1:0]   model_perm;
   logic [ATTR_W-1:0]   model_mask;
   logic [7:0]          model_store [STORE_BYTES];

   bus_reply_type     expected_replies [$];
   bit                pinned_flags [$];
   bus_reply_type     pinned_replies [$];
   logic [ADDR_W-1:0] written_addresses [$];
   script_row_type    directed_rows [$];

   int error_count = 0;
   int quiet_cycles = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   region_mapped_memory_access u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_address      (req_address),
      .req_width_code   (req_width_code),
      .req_write_value  (req_write_value),
      .req_access_attr  (req_access_attr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status)
   );

   always #10 clock = ~clock;

   // Effective region size: oversized settings saturate at the store size of one region.
   function automatic int unsigned span_of(input int r);
      return (model_bytes[r] > REGION_BYTES) ? REGION_BYTES : int'(model_bytes[r]);
   endfunction

   // Decodes one word against the regions and applies it to the mirrored store.
   function automatic bus_reply_type perform_access(input bus_access_type a);
      bus_reply_type reply;
      int hit;
      int nbytes;
      int r;
      int i;
      longint unsigned addr;
      longint unsigned base;
      longint unsigned offset;
      int slot;
      logic [ATTR_W-1:0] rattr;
      reply.read_value = '0;
      reply.status = STATUS_SECTION;
      hit = -1;
      addr = a.address;
      nbytes = a.width_code[1] ? 4 : (a.width_code[0] ? 2 : 1);
      // Scan from the top so that the lowest-numbered matching region wins.
      for (r = NUM_REGIONS - 1; r >= 0; r--) begin
         base = model_base[r];
         if (span_of(r) != 0 && addr >= base && addr < base + span_of(r)) begin
            hit = r;
         end
      end
      if (hit >= 0) begin
         offset = addr - longint'(model_base[hit]);
         rattr = model_perm[8*hit +: 8];
         if (offset + nbytes > span_of(hit)) begin
            reply.status = STATUS_SECTION;
         end else if ((rattr & a.access_attr & model_mask) == '0) begin
            reply.status = STATUS_ATTR;
         end else begin
            reply.status = STATUS_OK;
            slot = hit * REGION_BYTES + int'(offset);
            for (i = 0; i < nbytes; i++) begin
               if (a.cmd == CMD_WRITE) begin
                  model_store[slot + i] = a.write_value[8*i +: 8];
               end else begin
                  reply.read_value[8*i +: 8] = model_store[slot + i];
               end
            end
         end
      end
      return reply;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < PRINT_LIMIT) begin
         $display("MISMATCH %s: got 0x%08h, expected 0x%08h", what, got, want);
      end
      error_count++;
   endtask

   // Register write; the enable is lowered by the next bus word or left for the next write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      case (idx)
         CSR_REGION0_BASE, CSR_REGION1_BASE, CSR_REGION2_BASE: begin
            model_base[idx - CSR_REGION0_BASE] = value;
         end
         CSR_REGION0_BYTES, CSR_REGION1_BYTES, CSR_REGION2_BYTES: begin
            model_bytes[idx - CSR_REGION0_BYTES] = value[RBYTES_W-1:0];
         end
         CSR_PERMISSIONS: begin
            model_perm = value[PERM_W-1:0];
         end
         CSR_CRITICAL_MASK: begin
            model_mask = value[ATTR_W-1:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   // Offers one word after a random gap and returns at the falling edge after acceptance.
   task automatic send_access(input bus_access_type a, input bit pinned,
                              input bus_reply_type reply);
      csr_write_enable = 1'b0;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      pinned_flags.push_back(pinned);
      pinned_replies.push_back(reply);
      req_cmd = a.cmd;
      req_address = a.address;
      req_width_code = a.width_code;
      req_write_value = a.write_value;
      req_access_attr = a.access_attr;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stops offering and waits until every expected response is back.
   task automatic drain_results();
      req_valid = 1'b0;
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Random word: mostly inside a live region with a passing attribute, some read-backs
   // of earlier writes, and some noise anywhere in the address space.
   function automatic bus_access_type random_access();
      bus_access_type a;
      int r;
      int pick;
      int unsigned span;
      logic [ATTR_W-1:0] lane;
      a.cmd = $urandom_range(1);
      a.address = $urandom();
      a.width_code = $urandom_range(3);
      a.write_value = $urandom();
      a.access_attr = $urandom();
      r = $urandom_range(NUM_REGIONS - 1);
      pick = $urandom_range(99);
      if (pick < 30 && written_addresses.size() > 0) begin
         a.address = written_addresses[$urandom_range(written_addresses.size() - 1)];
         a.cmd = CMD_READ;
      end else if (pick < 85) begin
         span = span_of(r);
         if (span != 0) begin
            a.address = model_base[r] + ADDR_W'($urandom_range(span - 1));
         end
      end
      lane = model_perm[8*r +: 8] & model_mask;
      if ($urandom_range(99) < 80) begin
         a.access_attr = a.access_attr | lane;
      end
      if (a.cmd == CMD_WRITE) begin
         if (written_addresses.size() < 64) begin
            written_addresses.push_back(a.address);
         end else begin
            written_addresses[$urandom_range(63)] = a.address;
         end
      end
      return a;
   endfunction

   // Region layout for one random phase; the first phase pins the address extremes.
   task automatic setup_regions(input int phase);
      int r;
      logic [ADDR_W-1:0] base;
      logic [CSR_DATA_W-1:0] bytes_value;
      for (r = 0; r < NUM_REGIONS; r++) begin
         case ($urandom_range(4))
            0: base = '0;
            1: base = 32'hFFFF_FFFF - $urandom_range(4095);
            2: base = model_base[0] + $urandom_range(2048);
            default: base = $urandom();
         endcase
         case ($urandom_range(5))
            0: bytes_value = 0;
            1: bytes_value = $urandom_range(8, 1);
            2: bytes_value = REGION_BYTES;
            3: bytes_value = $urandom_range(8191, REGION_BYTES + 1);
            default: bytes_value = $urandom_range(REGION_BYTES, 1);
         endcase
         if (phase == 0) begin
            base = (r == 0) ? 32'h0 : ((r == 1) ? 32'hFFFF_FFFF : 32'h0000_0800);
            bytes_value = (r == 1) ? 8191 : REGION_BYTES;
         end
         write_csr(CSR_REGION0_BASE + r, base);
         write_csr(CSR_REGION0_BYTES + r, bytes_value);
      end
      write_csr(CSR_PERMISSIONS, (phase == 0) ? 32'h00FF_FFFF : {8'h0, 24'($urandom())});
      write_csr(CSR_CRITICAL_MASK, (phase == 1) ? 32'($urandom_range(255, 1)) : 32'hFF);
      csr_write_enable = 1'b0;
   endtask

   function automatic script_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [CSR_DATA_W-1:0] value);
      script_row_type row;
      row = '{kind: ROW_CSR, index: idx, value: value, word: '0, pinned: 1'b0, reply: '0};
      return row;
   endfunction

   function automatic script_row_type access_row(input logic cmd, input logic [31:0] addr,
                                                 input logic [1:0] wc,
                                                 input logic [31:0] data,
                                                 input logic [7:0] attr);
      script_row_type row;
      row = '{kind: ROW_ACCESS, index: '0, value: '0, word: '{cmd, addr, wc, data, attr},
              pinned: 1'b0, reply: '0};
      return row;
   endfunction

   function automatic script_row_type pinned_row(input logic cmd, input logic [31:0] addr,
                                                 input logic [1:0] wc,
                                                 input logic [31:0] data,
                                                 input logic [7:0] attr,
                                                 input logic [31:0] rv,
                                                 input status_type st);
      script_row_type row;
      row = access_row(cmd, addr, wc, data, attr);
      row.pinned = 1'b1;
      row.reply = '{rv, st};
      return row;
   endfunction

   // Receiver: random ready, or a long hold-off when the stimulus asks for one.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left = LONG_HOLD - 1;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Scoreboard: check the response word first, then predict the accepted request word.
   always @(posedge clock) begin : scoreboard
      bus_reply_type want;
      bus_reply_type predicted;
      bus_reply_type pinned_reply;
      bit pinned;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("response word with nothing outstanding, status",
                               32'(rsp_status), 32'(0));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               end
               if (rsp_status !== want.status) begin
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted = perform_access('{req_cmd, req_address, req_width_code,
                                         req_write_value, req_access_attr});
            pinned = pinned_flags.pop_front();
            pinned_reply = pinned_replies.pop_front();
            expected_replies.push_back(pinned ? pinned_reply : predicted);
         end
      end
   end

   // Watchdog: too long without any word moving on either channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int k;
      int phase;
      int n;
      script_row_type row;
      bus_reply_type no_reply;
      no_reply = '0;
      for (k = 0; k < NUM_REGIONS; k++) begin
         model_base[k] = '0;
         model_bytes[k] = '0;
      end
      model_perm = '0;
      model_mask = CRITICAL_MASK_RESET;
      for (k = 0; k < STORE_BYTES; k++) model_store[k] = 8'h00;

      // Directed script. Region zero and region two overlap; region one ends exactly
      // at the top of the address space; region two is oversized and saturates.
      directed_rows.push_back(pinned_row(CMD_READ, 32'h0, WIDTH_BYTE, 0, 8'hFF,
                                         0, STATUS_SECTION));
      directed_rows.push_back(pinned_row(CMD_WRITE, 32'hFFFF_FFFF, WIDTH_WORD, 32'hFFFF_FFFF,
                                         8'hFF, 0, STATUS_SECTION));
      directed_rows.push_back(csr_row(CSR_REGION0_BASE, 32'h0000_1000));
      directed_rows.push_back(csr_row(CSR_REGION0_BYTES, 32'h100));
      directed_rows.push_back(csr_row(CSR_REGION1_BASE, 32'hFFFF_F000));
      directed_rows.push_back(csr_row(CSR_REGION1_BYTES, 32'h1000));
      directed_rows.push_back(csr_row(CSR_REGION2_BASE, 32'h0000_10F0));
      directed_rows.push_back(csr_row(CSR_REGION2_BYTES, 32'h1FFF));
      directed_rows.push_back(csr_row(CSR_PERMISSIONS, 32'h00FF_8001));
      directed_rows.push_back(csr_row(CSR_CRITICAL_MASK, 32'hFF));
      directed_rows.push_back(pinned_row(CMD_WRITE, 32'h1000, WIDTH_WORD, 32'hDEAD_BEEF,
                                         8'h01, 0, STATUS_OK));
      directed_rows.push_back(pinned_row(CMD_READ, 32'h1000, WIDTH_WORD, 0, 8'h01,
                                         32'hDEAD_BEEF, STATUS_OK));
      directed_rows.push_back(pinned_row(CMD_READ, 32'h1003, WIDTH_BYTE, 0, 8'h01,
                                         32'hDE, STATUS_OK));
      directed_rows.push_back(pinned_row(CMD_READ, 32'h1002, WIDTH_HALF, 0, 8'h01,
                                         32'hDEAD, STATUS_OK));
      directed_rows.push_back(access_row(CMD_WRITE, 32'h1001, WIDTH_BYTE, 32'hFFFF_FF55, 8'hFF));
      directed_rows.push_back(access_row(CMD_READ, 32'h1000, WIDTH_WORD, 0, 8'h01));
      directed_rows.push_back(pinned_row(CMD_READ, 32'h1000, WIDTH_WORD, 0, 8'hFE,
                                         0, STATUS_ATTR));
      // Inside region two as well, but region zero matches first and is overrun.
      directed_rows.push_back(pinned_row(CMD_WRITE, 32'h10FF, WIDTH_HALF, 32'hFFFF_FFFF,
                                         8'h01, 0, STATUS_SECTION));
      directed_rows.push_back(access_row(CMD_WRITE, 32'h1100, WIDTH_WORD, 32'hA5C3_0F1E, 8'hFF));
      directed_rows.push_back(access_row(CMD_READ, 32'h1100, WIDTH_SPARE, 0, 8'h80));
      directed_rows.push_back(pinned_row(CMD_WRITE, 32'hFFFF_FFFC, WIDTH_WORD, 32'h1234_5678,
                                         8'h80, 0, STATUS_OK));
      directed_rows.push_back(pinned_row(CMD_READ, 32'hFFFF_FFFC, WIDTH_WORD, 0, 8'h80,
                                         32'h1234_5678, STATUS_OK));
      directed_rows.push_back(pinned_row(CMD_READ, 32'hFFFF_FFFF, WIDTH_HALF, 0, 8'h80,
                                         0, STATUS_SECTION));
      directed_rows.push_back(pinned_row(CMD_READ, 32'hFFFF_FFFF, WIDTH_BYTE, 0, 8'h80,
                                         32'h12, STATUS_OK));
      directed_rows.push_back(pinned_row(CMD_READ, 32'h0FFF, WIDTH_WORD, 0, 8'hFF,
                                         0, STATUS_SECTION));
      directed_rows.push_back(access_row(CMD_READ, 32'h20EF, WIDTH_BYTE, 0, 8'h01));
      directed_rows.push_back(pinned_row(CMD_READ, 32'h20F0, WIDTH_BYTE, 0, 8'hFF,
                                         0, STATUS_SECTION));
      directed_rows.push_back(pinned_row(CMD_WRITE, 32'h1000, WIDTH_WORD, 32'h0, 8'h00,
                                         0, STATUS_ATTR));
      directed_rows.push_back(csr_row(CSR_CRITICAL_MASK, 32'h7F));
      directed_rows.push_back(pinned_row(CMD_READ, 32'hFFFF_FFFC, WIDTH_WORD, 0, 8'hFF,
                                         0, STATUS_ATTR));
      directed_rows.push_back(access_row(CMD_READ, 32'h1000, WIDTH_WORD, 0, 8'h01));
      directed_rows.push_back(csr_row(CSR_CRITICAL_MASK, 32'h00));
      directed_rows.push_back(pinned_row(CMD_READ, 32'h1000, WIDTH_BYTE, 0, 8'hFF,
                                         0, STATUS_ATTR));
      directed_rows.push_back(csr_row(CSR_REGION0_BYTES, 32'h0));
      directed_rows.push_back(pinned_row(CMD_READ, 32'h1000, WIDTH_BYTE, 0, 8'hFF,
                                         0, STATUS_SECTION));

      // Synchronous reset; the block then clears its store before taking words.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      sender_idle_pct = 33;
      receiver_idle_pct = 55;
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.kind == ROW_CSR) begin
            drain_results();
            write_csr(row.index, row.value);
         end else begin
            send_access(row.word, row.pinned, row.reply);
         end
      end

      // Random phases with different idling on each side.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 33;
               receiver_idle_pct = 55;
            end
            1: begin
               sender_idle_pct = 55;
               receiver_idle_pct = 33;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         drain_results();
         written_addresses.delete();
         setup_regions(phase);
         for (n = 0; n < PHASE_WORDS; n++) begin
            // Long receiver hold-off with the sender still offering, then a full drain.
            if (n == PHASE_WORDS / 3) hold_requests++;
            if (n == 2 * PHASE_WORDS / 3) drain_results();
            send_access(random_access(), 1'b0, no_reply);
         end
      end

      drain_results();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
